@@ sv/rau_pkg.sv @@
// Shared constants, codes and types for the rational arithmetic unit.
package rau_pkg;
    localparam int WORD_BITS = 32;
    localparam int MAG_BITS  = 2 * WORD_BITS + 1;   // magnitudes of raw terms and sums

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef logic [MAG_BITS-1:0] t_mag;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] a_numerator;
        logic [31:0] a_denominator;
        logic [31:0] b_numerator;
        logic [31:0] b_denominator;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] result_numerator;
        logic [30:0] result_denominator;
        logic [1:0]  status;
    } t_out_beat;
endpackage

@@ sv/rau_if.sv @@
// Valid/ready channel interfaces for operand and result beats.
interface rau_in_if import rau_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rau_out_if import rau_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/rational_arithmetic_unit.sv @@
// Top level: rational add/sub/mul/div with gcd reduction over a shared divider.
//  channel   dir  handshake        payload
//  i_in      in   valid/ready      op, a/b numerator and denominator
//  o_out     out  valid/ready      result numerator, denominator, status
// One 32x32 multiplier forms the three products in turn; the shared 65-step
// restoring divider runs each Euclid remainder step and the two final
// quotients. i_in.ready is high only in idle; a finished result waits in a
// staging register while the previous beat stalls in the output register.
// Reset is synchronous.
module rational_arithmetic_unit import rau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_COMB = 4'd2;
    localparam logic [3:0] S_GCD  = 4'd3;
    localparam logic [3:0] S_GWT  = 4'd4;
    localparam logic [3:0] S_DN   = 4'd5;
    localparam logic [3:0] S_DNW  = 4'd6;
    localparam logic [3:0] S_DD   = 4'd7;
    localparam logic [3:0] S_DDW  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]  r_state;
    logic [1:0]  r_op;
    logic [31:0] r_mag [4];     // |an| |ad| |bn| |bd|
    logic [3:0]  r_neg;
    logic [1:0]  r_mcnt;
    logic [63:0] r_prod [3];
    t_mag        r_num, r_den, r_x, r_y, r_g;
    logic        r_nn;
    t_out_beat   r_res;
    t_out_beat   r_out;
    logic        r_ovalid;

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_p;
    logic        w_dstart, w_ddone;
    t_mag        w_dvd, w_dvs, w_quo, w_rem;

    // magnitude of a two's complement word
    function automatic logic [31:0] f_abs(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // product selection: an*bd, bn*ad, ad*bd, an*bn / ad*bn
    always_comb begin
        w_ma = r_mag[0];
        w_mb = r_mag[3];
        case (r_mcnt)
            2'd0: begin w_ma = r_mag[0]; w_mb = (r_op == OP_MUL) ? r_mag[2] : r_mag[3]; end
            2'd1: begin w_ma = r_mag[2]; w_mb = r_mag[1]; end
            2'd2: begin w_ma = r_mag[1]; w_mb = (r_op == OP_DIV) ? r_mag[2] : r_mag[3]; end
            default: begin w_ma = r_mag[0]; w_mb = r_mag[3]; end
        endcase
    end
    assign w_p = w_ma * w_mb;

    // combine the raw products into a signed-magnitude result
    logic        w_xn, w_yn, w_nn0, w_dn;
    t_mag        w_px, w_py, w_sum;
    logic        w_sn;
    always_comb begin
        w_px = MAG_BITS'(r_prod[0]);
        w_py = MAG_BITS'(r_prod[1]);
        w_xn = r_neg[0] ^ r_neg[3];
        w_yn = ((r_op == OP_SUB) ? ~r_neg[2] : r_neg[2]) ^ r_neg[1];
        if (w_xn == w_yn) begin
            w_sum = w_px + w_py; w_sn = w_xn;
        end else if (w_px >= w_py) begin
            w_sum = w_px - w_py; w_sn = w_xn;
        end else begin
            w_sum = w_py - w_px; w_sn = w_yn;
        end
        case (r_op)
            OP_ADD, OP_SUB: w_nn0 = w_sn;
            OP_MUL:         w_nn0 = r_neg[0] ^ r_neg[2];
            default:        w_nn0 = r_neg[0] ^ r_neg[3];
        endcase
        w_dn = (r_op == OP_DIV) ? (r_neg[1] ^ r_neg[2]) : (r_neg[1] ^ r_neg[3]);
    end

    // divider operand selection per phase
    always_comb begin
        w_dvd    = r_x;
        w_dvs    = r_y;
        w_dstart = 1'b0;
        case (r_state)
            S_GCD: begin w_dstart = 1'b1; end
            S_DN:  begin w_dstart = 1'b1; w_dvd = r_num; w_dvs = r_g; end
            S_DD:  begin w_dstart = 1'b1; w_dvd = r_den; w_dvs = r_g; end
            default: w_dstart = 1'b0;
        endcase
    end

    rau_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_dstart),
        .i_dividend  (w_dvd),
        .i_divisor   (w_dvs),
        .o_done      (w_ddone),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    localparam t_mag LIM = t_mag'(1) << (WORD_BITS - 1);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_mcnt   <= '0;
        end else begin
            // raise valid on a new result, drop it once the beat is taken
            if (r_state == S_OUT && (!r_ovalid || o_out.ready)) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op     <= i_in.data.op;
                        r_mag[0] <= f_abs(i_in.data.a_numerator);
                        r_mag[1] <= f_abs(i_in.data.a_denominator);
                        r_mag[2] <= f_abs(i_in.data.b_numerator);
                        r_mag[3] <= f_abs(i_in.data.b_denominator);
                        r_neg    <= {i_in.data.b_denominator[31], i_in.data.b_numerator[31],
                                     i_in.data.a_denominator[31], i_in.data.a_numerator[31]};
                        r_mcnt   <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod[r_mcnt] <= w_p;
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd2) r_state <= S_COMB;
                end
                S_COMB: begin
                    r_den <= MAG_BITS'(r_prod[2]);
                    r_num <= (r_op <= OP_SUB) ? w_sum : MAG_BITS'(r_prod[0]);
                    r_x   <= (r_op <= OP_SUB) ? w_sum : MAG_BITS'(r_prod[0]);
                    r_y   <= MAG_BITS'(r_prod[2]);
                    if (r_prod[2] == '0) begin
                        r_res    <= '{result_numerator: '0, result_denominator: '0,
                                      status: ST_DIV0};
                        r_state  <= S_OUT;
                    end else begin
                        r_nn    <= ((r_op <= OP_SUB) ? (w_sum != '0) : (r_prod[0] != '0))
                                   && (w_nn0 != w_dn);
                        r_state <= S_GCD;
                    end
                end
                S_GCD: r_state <= S_GWT;
                S_GWT: begin
                    if (w_ddone) begin
                        r_x <= r_y;
                        r_y <= w_rem;
                        if (w_rem == '0) begin
                            r_g     <= r_y;
                            r_state <= S_DN;
                        end else begin
                            r_state <= S_GCD;
                        end
                    end
                end
                S_DN: r_state <= S_DNW;
                S_DNW: if (w_ddone) begin r_num <= w_quo; r_state <= S_DD; end
                S_DD: r_state <= S_DDW;
                S_DDW: begin
                    if (w_ddone) begin
                        if (r_num > (r_nn ? LIM : LIM - 1'b1) || w_quo > LIM - 1'b1) begin
                            r_res <= '{result_numerator: '0, result_denominator: '0,
                                       status: ST_OVF};
                        end else begin
                            r_res.result_numerator   <= r_nn ? (32'd0 - r_num[31:0])
                                                             : r_num[31:0];
                            r_res.result_denominator <= w_quo[30:0];
                            r_res.status             <= ST_OK;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hand the result over once the output register is free
                    if (!r_ovalid || o_out.ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready) else $error("ready while busy");
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status == ST_OK) |-> (o_out.data.result_denominator != '0))
        else $error("ok result with zero denominator");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status != ST_OK) |-> (o_out.data.result_numerator == '0))
        else $error("error result with nonzero numerator");
endmodule

@@ sv/rau_divider.sv @@
// Restoring divider, one quotient bit per cycle, returns quotient and remainder.
module rau_divider import rau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_mag i_dividend,
    input  t_mag i_divisor,
    output logic o_done,
    output t_mag o_quotient,
    output t_mag o_remainder
);
    localparam int CNT_BITS = $clog2(MAG_BITS + 1);

    logic                r_busy;
    logic [CNT_BITS-1:0] r_cnt;
    t_mag                r_q;
    t_mag                r_r;
    t_mag                r_d;
    logic                r_done;
    logic [MAG_BITS:0]   w_trial;
    t_mag                w_shift;

    // shift in next dividend bit, try subtract
    assign w_shift = {r_r[MAG_BITS-2:0], r_q[MAG_BITS-1]};
    assign w_trial = {r_r[MAG_BITS-1], w_shift} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(MAG_BITS);
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                if (!w_trial[MAG_BITS]) begin
                    r_r <= w_trial[MAG_BITS-1:0];
                    r_q <= {r_q[MAG_BITS-2:0], 1'b1};
                end else begin
                    r_r <= w_shift;
                    r_q <= {r_q[MAG_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_r;

    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("divider done held two cycles");
    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("divider done while busy");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start) |=> (r_cnt == $past(r_cnt) - 1'b1) || i_start || $past(i_start))
        else $error("divider count skipped");
endmodule

@@ tb/sv/rau_fraction_checker.sv @@
// Checker for the rational arithmetic unit: predicts reduced fractions and compares.
module rau_fraction_checker import rau_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rau_in_if.sink      i_in,
    rau_out_if.sink     i_out,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_out_beat fractions_due[$];
    int        mismatches;

    // Split a signed word into magnitude and sign.
    function automatic logic [63:0] word_mag(input logic [31:0] w, output bit neg);
        neg = w[31];
        return neg ? 64'(-{32'd0, w} & 64'hFFFF_FFFF) : {32'd0, w};
    endfunction

    // Add two signed magnitudes.
    function automatic logic [63:0] mag_sum(input logic [63:0] x, input bit xn,
                                            input logic [63:0] y, input bit yn,
                                            output bit rn);
        logic [63:0] r;
        if (xn == yn) begin
            r = x + y;
            rn = xn;
        end else if (x >= y) begin
            r = x - y;
            rn = xn;
        end else begin
            r = y - x;
            rn = yn;
        end
        if (r == 0) rn = 0;
        return r;
    endfunction

    // Work out the reduced fraction and status for one operand beat.
    function automatic t_out_beat reduce_fraction(input t_in_beat b);
        bit          ann, adn, bnn, bdn, nn, dn;
        logic [63:0] an, ad, bn, bd, num, den, x, y, t, lim;
        t_out_beat   r;
        an = word_mag(b.a_numerator, ann);
        ad = word_mag(b.a_denominator, adn);
        bn = word_mag(b.b_numerator, bnn);
        bd = word_mag(b.b_denominator, bdn);
        lim = 64'd1 << 31;
        r = '0;
        case (b.op)
            OP_ADD, OP_SUB: begin
                num = mag_sum(an * bd, ann != bdn, bn * ad,
                              ((b.op == OP_SUB) ? !bnn : bnn) != adn, nn);
                den = ad * bd;
                dn = adn != bdn;
            end
            OP_MUL: begin
                num = an * bn;
                nn = ann != bnn;
                den = ad * bd;
                dn = adn != bdn;
            end
            default: begin
                num = an * bd;
                nn = ann != bdn;
                den = ad * bn;
                dn = adn != bnn;
            end
        endcase
        if (den == 0) begin
            r.status = ST_DIV0;
            return r;
        end
        nn = (num != 0) && (nn != dn);
        x = num;
        y = den;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        num = num / x;
        den = den / x;
        if (num > (nn ? lim : lim - 1) || den > lim - 1) begin
            r.status = ST_OVF;
            return r;
        end
        r.result_numerator = nn ? 32'(-num) : num[31:0];
        r.result_denominator = den[30:0];
        r.status = ST_OK;
        return r;
    endfunction

    assign o_errors = mismatches;
    assign o_pending = fractions_due.size();

    // Queue predictions on operand beats, compare on result beats.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) fractions_due.push_back(reduce_fraction(i_in.data));
            if (i_out.valid && i_out.ready) begin
                if (fractions_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %p", i_out.data);
                end else begin
                    want = fractions_due.pop_front();
                    if (want !== i_out.data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d st %0d, got %0d/%0d st %0d",
                                     $signed(want.result_numerator), want.result_denominator,
                                     want.status, $signed(i_out.data.result_numerator),
                                     i_out.data.result_denominator, i_out.data.status);
                    end
                end
            end
        end
    end
endmodule

@@ tb/sv/tb_rational_arithmetic_unit.sv @@
// Testbench top for the rational arithmetic unit: stimulus, stalls and verdict.
module tb_rational_arithmetic_unit import rau_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 1750;
    localparam int STALL_LIMIT  = 200000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending, idle_cycles;
    bit   timed_out;

    rau_in_if  in_ch();
    rau_out_if out_ch();

    rational_arithmetic_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    rau_fraction_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .i_out(out_ch.sink),
        .o_errors(errors), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    // Stall the result side on its own pattern, with calm stretches.
    always @(posedge i_clk) begin
        int phase;
        phase = $urandom_range(0, 99);
        if (($time / 20000) % 3 == 0) out_ch.ready <= 1'b1;
        else out_ch.ready <= (phase < 65);
    end

    // Pick a word that stresses edges: extremes, small values, or random.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4, 5: return 32'($signed($urandom_range(0, 40)) - 20);
            6: return 32'($urandom_range(1, 1000)) * 32'($urandom_range(1, 1000));
            default: return $urandom;
        endcase
    endfunction

    // Drive one beat and hold it until accepted.
    task automatic send_beat(input t_in_beat b);
        in_ch.valid <= 1'b1;
        in_ch.data <= b;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic go_idle(input int gap);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    // Count cycles with no beat moving; give up past the limit.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_in_beat b;
        logic [31:0] dir_words[6];
        int burst;
        dir_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd6};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every op over extreme and special operands.
        b = '{OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3};
        send_beat(b);
        b = '{OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2};
        send_beat(b);
        b = '{OP_MUL, 32'd0, 32'd5, 32'd7, 32'd3};
        send_beat(b);
        b = '{OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5};
        send_beat(b);
        b = '{OP_DIV, 32'd3, 32'd4, 32'd7, 32'd0};
        send_beat(b);
        b = '{OP_MUL, 32'd3, 32'd0, 32'd7, 32'd9};
        send_beat(b);
        b = '{OP_ADD, 32'd1, 32'hFFFF_FFFE, 32'd1, 32'hFFFF_FFFD};
        send_beat(b);
        for (int k = 0; k < 16; k++) begin
            b.op = 2'(k);
            b.a_numerator = dir_words[k % 6];
            b.a_denominator = dir_words[(k + 3) % 6];
            b.b_numerator = dir_words[(k + 1) % 6];
            b.b_denominator = dir_words[(k + 4) % 6];
            send_beat(b);
        end

        // Random bursts with random gaps.
        for (int n = 0; n < RANDOM_BEATS; n += burst) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) begin
                b.op = 2'($urandom_range(0, 3));
                b.a_numerator = pick_word();
                b.a_denominator = pick_word();
                b.b_numerator = pick_word();
                b.b_denominator = pick_word();
                send_beat(b);
            end
            if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 300));
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ rational_arithmetic_unit.f @@
sv/rau_pkg.sv
sv/rau_if.sv
sv/rau_divider.sv
sv/rational_arithmetic_unit.sv
tb/sv/rau_fraction_checker.sv
tb/sv/tb_rational_arithmetic_unit.sv
